>>> design/spherical_rotation_matrix_defines.svh
// ----------------------------------------------------------------------------
// spherical_rotation_matrix_defines.svh
// Assertion macros shared by the rotation matrix term pipeline.
// ----------------------------------------------------------------------------
`ifndef SPHERICAL_ROTATION_MATRIX_DEFINES_SVH
`define SPHERICAL_ROTATION_MATRIX_DEFINES_SVH

// Same-cycle implication, checked on clk, quiet while rst_n is low.
`define SRM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, quiet while rst_n is low.
`define SRM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/srm_pkg.sv
// ----------------------------------------------------------------------------
// srm_pkg
// Widths, CORDIC constants, result type and rounding helpers.
// ----------------------------------------------------------------------------
package srm_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int VALUE_BITS   = 16;
  localparam int FRAC_BITS    = VALUE_BITS - 1;
  localparam int TURN_BITS    = 32;
  localparam int WORK_BITS    = 32;
  localparam int WORK_FRAC    = 30;
  localparam int CORDIC_STEPS = 30;
  localparam int PROD_BITS    = 2 * VALUE_BITS;

  // input register + one stage per step + quadrant/round stage
  localparam int CORDIC_LAT = CORDIC_STEPS + 2;
  localparam int PROD_LAT   = 2;
  localparam int PIPE_DEPTH = CORDIC_LAT + PROD_LAT;
  localparam int PIPE_LAST  = PIPE_DEPTH - 1;

  // work value to output scaling
  localparam int RSH = (WORK_FRAC > FRAC_BITS) ? (WORK_FRAC - FRAC_BITS) : 0;
  localparam int LSH = (FRAC_BITS > WORK_FRAC) ? (FRAC_BITS - WORK_FRAC) : 0;
  localparam longint RND      = (RSH > 0) ? (longint'(1) << (RSH - 1)) : longint'(0);
  localparam longint PROD_RND = longint'(1) << (FRAC_BITS - 1);

  localparam int ROUND_BITS = WORK_BITS + 2 + LSH;
  localparam int SAT_BITS   = (ROUND_BITS > PROD_BITS + 2) ? ROUND_BITS : PROD_BITS + 2;

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic signed [WORK_BITS-1:0]  work_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [SAT_BITS-1:0]   wide_t;

  // gain-compensated start vector, Q2.30
  localparam work_t X_INIT = 32'sh26DD3B6A;

  typedef enum logic [1:0] {
    QUAD_FIRST  = 2'd0,
    QUAD_SECOND = 2'd1,
    QUAD_THIRD  = 2'd2,
    QUAD_FOURTH = 2'd3
  } quad_t;

  typedef struct packed {
    value_t cos_beta;
    value_t sin_beta;
    value_t cos_lambda;
    value_t sin_lambda;
    value_t cb_times_cl;
    value_t cb_times_sl;
    value_t sb_times_cl;
    value_t sb_times_sl;
  } result_t;

  // atan(2^-i) in 2^32-per-turn units
  function automatic work_t atan_turn(input int unsigned i);
    case (i)
      0:       return 32'sd536870912;
      1:       return 32'sd316933406;
      2:       return 32'sd167458907;
      3:       return 32'sd85004756;
      4:       return 32'sd42667331;
      5:       return 32'sd21354465;
      6:       return 32'sd10679838;
      7:       return 32'sd5340245;
      8:       return 32'sd2670163;
      9:       return 32'sd1335087;
      10:      return 32'sd667544;
      11:      return 32'sd333772;
      12:      return 32'sd166886;
      13:      return 32'sd83443;
      14:      return 32'sd41722;
      15:      return 32'sd20861;
      16:      return 32'sd10430;
      17:      return 32'sd5215;
      18:      return 32'sd2608;
      19:      return 32'sd1304;
      20:      return 32'sd652;
      21:      return 32'sd326;
      22:      return 32'sd163;
      23:      return 32'sd81;
      24:      return 32'sd41;
      25:      return 32'sd20;
      26:      return 32'sd10;
      27:      return 32'sd5;
      28:      return 32'sd3;
      29:      return 32'sd1;
      default: return '0;
    endcase
  endfunction

  // clamp to +/-(2^FRAC_BITS - 1)
  function automatic value_t sat_value(input wide_t v);
    wide_t lim;
    lim = {{(SAT_BITS - FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};
    if (v > lim) begin
      return value_t'(lim);
    end else if (v < -lim) begin
      return value_t'(-lim);
    end
    return value_t'(v);
  endfunction

  // round half up from WORK_FRAC fraction bits to FRAC_BITS, then clamp
  function automatic value_t round_work(input logic signed [WORK_BITS:0] v);
    wide_t t;
    t = SAT_BITS'(v);
    t = ((t + SAT_BITS'(RND)) >>> RSH) <<< LSH;
    return sat_value(t);
  endfunction

endpackage

>>> design/srm_cordic.sv
// ----------------------------------------------------------------------------
// srm_cordic
// Pipelined rotation-mode CORDIC: one step per stage, quadrant fold, rounding.
// ----------------------------------------------------------------------------
module srm_cordic (
  input  logic                              clk,
  input  logic                              en,
  input  logic [srm_pkg::ANGLE_BITS-1:0]    angle,
  output srm_pkg::value_t                   cos_val,
  output srm_pkg::value_t                   sin_val
);

  logic [srm_pkg::TURN_BITS-1:0]     a32;
  srm_pkg::work_t                    x_r    [0:srm_pkg::CORDIC_STEPS];
  srm_pkg::work_t                    y_r    [0:srm_pkg::CORDIC_STEPS];
  srm_pkg::work_t                    z_r    [0:srm_pkg::CORDIC_STEPS-1];
  srm_pkg::quad_t                    quad_r [0:srm_pkg::CORDIC_STEPS];
  srm_pkg::work_t                    x_nxt  [0:srm_pkg::CORDIC_STEPS-1];
  srm_pkg::work_t                    y_nxt  [0:srm_pkg::CORDIC_STEPS-1];
  srm_pkg::work_t                    z_nxt  [0:srm_pkg::CORDIC_STEPS-2];
  logic [srm_pkg::CORDIC_STEPS-1:0]  rot_pos;
  logic signed [srm_pkg::WORK_BITS:0] xf, yf, rc, rs;
  srm_pkg::value_t                   cos_r, sin_r;

  // scale to a 32-bit turn
  assign a32 = srm_pkg::TURN_BITS'(angle) << (srm_pkg::TURN_BITS - srm_pkg::ANGLE_BITS);

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= srm_pkg::X_INIT;
      y_r[0]    <= '0;
      z_r[0]    <= srm_pkg::work_t'({2'b00, a32[srm_pkg::TURN_BITS-3:0]});
      quad_r[0] <= srm_pkg::quad_t'(a32[srm_pkg::TURN_BITS-1 -: 2]);
    end
  end

  for (genvar i = 0; i < srm_pkg::CORDIC_STEPS; i++) begin : g_step
    assign rot_pos[i] = !z_r[i][srm_pkg::WORK_BITS-1];
    assign x_nxt[i] = rot_pos[i] ? (x_r[i] - (y_r[i] >>> i)) : (x_r[i] + (y_r[i] >>> i));
    assign y_nxt[i] = rot_pos[i] ? (y_r[i] + (x_r[i] >>> i)) : (y_r[i] - (x_r[i] >>> i));

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i+1]    <= x_nxt[i];
        y_r[i+1]    <= y_nxt[i];
        quad_r[i+1] <= quad_r[i];
      end
    end

    // the last step leaves no residual angle to carry
    if (i < srm_pkg::CORDIC_STEPS - 1) begin : g_z
      assign z_nxt[i] = rot_pos[i] ? (z_r[i] - srm_pkg::atan_turn(i))
                                   : (z_r[i] + srm_pkg::atan_turn(i));

      always_ff @(posedge clk) begin
        if (en) begin
          z_r[i+1] <= z_nxt[i];
        end
      end
    end
  end

  assign xf = (srm_pkg::WORK_BITS + 1)'(x_r[srm_pkg::CORDIC_STEPS]);
  assign yf = (srm_pkg::WORK_BITS + 1)'(y_r[srm_pkg::CORDIC_STEPS]);

  // fold the first-quadrant result out to the full circle
  always_comb begin
    case (quad_r[srm_pkg::CORDIC_STEPS])
      srm_pkg::QUAD_FIRST: begin
        rc = xf;
        rs = yf;
      end
      srm_pkg::QUAD_SECOND: begin
        rc = -yf;
        rs = xf;
      end
      srm_pkg::QUAD_THIRD: begin
        rc = -xf;
        rs = -yf;
      end
      default: begin
        rc = yf;
        rs = -xf;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= srm_pkg::round_work(rc);
      sin_r <= srm_pkg::round_work(rs);
    end
  end

  assign cos_val = cos_r;
  assign sin_val = sin_r;

endmodule

>>> design/srm_product.sv
// ----------------------------------------------------------------------------
// srm_product
// Two-stage cross products: multiply, then round half up and clamp.
// ----------------------------------------------------------------------------
module srm_product (
  input  logic             clk,
  input  logic             en,
  input  srm_pkg::value_t  cos_beta,
  input  srm_pkg::value_t  sin_beta,
  input  srm_pkg::value_t  cos_lambda,
  input  srm_pkg::value_t  sin_lambda,
  output srm_pkg::result_t res
);

  srm_pkg::value_t  fac_a [0:3];
  srm_pkg::value_t  fac_b [0:3];
  srm_pkg::prod_t   prod_r [0:3];
  srm_pkg::value_t  term_r [0:3];
  srm_pkg::value_t  cb_r, sb_r, cl_r, sl_r;
  srm_pkg::result_t res_r;

  assign fac_a[0] = cos_beta;
  assign fac_b[0] = cos_lambda;
  assign fac_a[1] = cos_beta;
  assign fac_b[1] = sin_lambda;
  assign fac_a[2] = sin_beta;
  assign fac_b[2] = cos_lambda;
  assign fac_a[3] = sin_beta;
  assign fac_b[3] = sin_lambda;

  for (genvar k = 0; k < 4; k++) begin : g_lane
    always_ff @(posedge clk) begin
      if (en) begin
        prod_r[k] <= srm_pkg::PROD_BITS'(fac_a[k]) * srm_pkg::PROD_BITS'(fac_b[k]);
      end
    end
    assign term_r[k] = srm_pkg::sat_value(
        (srm_pkg::SAT_BITS'(prod_r[k]) + srm_pkg::SAT_BITS'(srm_pkg::PROD_RND))
        >>> srm_pkg::FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cb_r <= cos_beta;
      sb_r <= sin_beta;
      cl_r <= cos_lambda;
      sl_r <= sin_lambda;
      res_r.cos_beta    <= cb_r;
      res_r.sin_beta    <= sb_r;
      res_r.cos_lambda  <= cl_r;
      res_r.sin_lambda  <= sl_r;
      res_r.cb_times_cl <= term_r[0];
      res_r.cb_times_sl <= term_r[1];
      res_r.sb_times_cl <= term_r[2];
      res_r.sb_times_sl <= term_r[3];
    end
  end

  assign res = res_r;

endmodule

>>> design/spherical_rotation_matrix.sv
// ----------------------------------------------------------------------------
// spherical_rotation_matrix
// Sine, cosine and cross products of a latitude/longitude angle pair.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  in_     | input     | in_valid / in_ready   | beta_angle, lambda_angle
//  out_    | output    | out_valid / out_ready | cos/sin of both, four products
//
//  One request enters per cycle while in_ready is high; each result
//  passes one input register, 30 CORDIC stages, one quadrant/round stage,
//  one multiply stage and one product round stage.
//  Reset (rst_n, synchronous, active low) clears the stage valid bits and
//  the skid valid bit; datapath registers carry no reset.
//  A stalled output parks one result in the skid register; while it is full
//  the whole pipeline holds and in_ready is low, so nothing is lost or doubled.
//
`include "spherical_rotation_matrix_defines.svh"

module spherical_rotation_matrix (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [srm_pkg::ANGLE_BITS-1:0]  in_beta_angle,
  input  logic [srm_pkg::ANGLE_BITS-1:0]  in_lambda_angle,
  output logic                            out_valid,
  input  logic                            out_ready,
  output srm_pkg::value_t                 out_cos_beta,
  output srm_pkg::value_t                 out_sin_beta,
  output srm_pkg::value_t                 out_cos_lambda,
  output srm_pkg::value_t                 out_sin_lambda,
  output srm_pkg::value_t                 out_cb_times_cl,
  output srm_pkg::value_t                 out_cb_times_sl,
  output srm_pkg::value_t                 out_sb_times_cl,
  output srm_pkg::value_t                 out_sb_times_sl
);

  logic                           en;
  logic [srm_pkg::PIPE_DEPTH-1:0] vld_r, vld_nxt;
  logic                           last_vld;
  logic                           skid_vld_r, skid_vld_nxt;
  logic                           skid_load;
  srm_pkg::result_t               pipe_res, skid_r, out_res;
  srm_pkg::value_t                cb, sb, cl, sl;

  // Advance every stage together whenever the skid slot is free.
  assign en       = !skid_vld_r;
  assign in_ready = en;

  assign last_vld = vld_r[srm_pkg::PIPE_LAST];

  // Park the finished result when the sink stalls while the pipe advances.
  assign skid_load = en && last_vld && !out_ready;

  srm_cordic u_cordic_beta (
    .clk     (clk),
    .en      (en),
    .angle   (in_beta_angle),
    .cos_val (cb),
    .sin_val (sb)
  );

  srm_cordic u_cordic_lambda (
    .clk     (clk),
    .en      (en),
    .angle   (in_lambda_angle),
    .cos_val (cl),
    .sin_val (sl)
  );

  srm_product u_product (
    .clk        (clk),
    .en         (en),
    .cos_beta   (cb),
    .sin_beta   (sb),
    .cos_lambda (cl),
    .sin_lambda (sl),
    .res        (pipe_res)
  );

  // Valid bits shift alongside the data; hold them while frozen.
  always_comb begin
    vld_nxt = vld_r;
    if (en) begin
      vld_nxt = {vld_r[srm_pkg::PIPE_DEPTH-2:0], in_valid};
    end
  end

  // Set on a parked result, drop once the sink takes it.
  always_comb begin
    skid_vld_nxt = skid_vld_r;
    if (skid_vld_r) begin
      if (out_ready) begin
        skid_vld_nxt = 1'b0;
      end
    end else if (skid_load) begin
      skid_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      skid_vld_r <= 1'b0;
    end else begin
      vld_r      <= vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_load) begin
      skid_r <= pipe_res;
    end
  end

  // The parked result always goes out ahead of the pipe's last stage.
  assign out_res   = skid_vld_r ? skid_r : pipe_res;
  assign out_valid = skid_vld_r || last_vld;

  assign out_cos_beta    = out_res.cos_beta;
  assign out_sin_beta    = out_res.sin_beta;
  assign out_cos_lambda  = out_res.cos_lambda;
  assign out_sin_lambda  = out_res.sin_lambda;
  assign out_cb_times_cl = out_res.cb_times_cl;
  assign out_cb_times_sl = out_res.cb_times_sl;
  assign out_sb_times_cl = out_res.sb_times_cl;
  assign out_sb_times_sl = out_res.sb_times_sl;

  // An accepted request occupies the entry stage on the next cycle.
  `SRM_ASSERT_NEXT(a_entry_tracked, in_valid && in_ready, vld_r[0], "request lost at entry")
  // A full skid slot freezes every stage valid bit.
  `SRM_ASSERT_NEXT(a_pipe_frozen, skid_vld_r, $stable(vld_r), "pipeline moved while skid full")
  // The skid slot fills only from a valid last stage.
  `SRM_ASSERT_NOW(a_skid_source, $rose(skid_vld_r), $past(last_vld), "skid fill without result")

endmodule

>>> tb/sv/spherical_rotation_matrix_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spherical_rotation_matrix_tb
// Self-checking bench for the latitude/longitude sine, cosine and product
// pipeline. A bit-exact CORDIC predictor computes all eight terms for each
// accepted request. A monitor checks every result in order against those
// terms while both handshakes idle and stall at random, phase by phase.
// ----------------------------------------------------------------------------
module spherical_rotation_matrix_tb;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 12;
  localparam int PHASE_ITEMS  = 500;
  localparam int NUM_PHASES   = 4;
  // Fraction bits dropped when a Q2.30 CORDIC value becomes an output value.
  localparam int ROUND_SHIFT  = srm_pkg::WORK_FRAC - srm_pkg::FRAC_BITS;

  typedef struct packed {
    logic [srm_pkg::ANGLE_BITS-1:0] beta;
    logic [srm_pkg::ANGLE_BITS-1:0] lambda;
  } angle_pair_t;

  logic                           clk             = 1'b0;
  logic                           rst_n           = 1'b0;
  logic                           in_valid        = 1'b0;
  logic                           in_ready;
  logic [srm_pkg::ANGLE_BITS-1:0] in_beta_angle   = '0;
  logic [srm_pkg::ANGLE_BITS-1:0] in_lambda_angle = '0;
  logic                           out_valid;
  logic                           out_ready       = 1'b0;
  srm_pkg::value_t                out_cos_beta;
  srm_pkg::value_t                out_sin_beta;
  srm_pkg::value_t                out_cos_lambda;
  srm_pkg::value_t                out_sin_lambda;
  srm_pkg::value_t                out_cb_times_cl;
  srm_pkg::value_t                out_cb_times_sl;
  srm_pkg::value_t                out_sb_times_cl;
  srm_pkg::value_t                out_sb_times_sl;

  angle_pair_t      pending_angles[$];   // requests not yet offered
  srm_pkg::result_t expected_terms[$];   // predicted results, oldest first
  int               fail_count     = 0;
  int               send_idle_pct  = 0;  // chance in 100 that the sender idles
  int               recv_stall_pct = 0;  // chance in 100 that the receiver stalls

  // Rotation angles atan(2^-i) in 2^32-per-turn units.
  longint arctan_step [0:srm_pkg::CORDIC_STEPS-1] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81,
    41, 20, 10, 5, 3, 1
  };

  spherical_rotation_matrix u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_beta_angle   (in_beta_angle),
    .in_lambda_angle (in_lambda_angle),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_cos_beta    (out_cos_beta),
    .out_sin_beta    (out_sin_beta),
    .out_cos_lambda  (out_cos_lambda),
    .out_sin_lambda  (out_sin_lambda),
    .out_cb_times_cl (out_cb_times_cl),
    .out_cb_times_sl (out_cb_times_sl),
    .out_sb_times_cl (out_sb_times_cl),
    .out_sb_times_sl (out_sb_times_sl)
  );

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Clamp to +/-(2^FRAC_BITS - 1): +1.0 is not representable, and -1.0 is clamped too.
  function automatic srm_pkg::value_t clamp_unit(input longint v);
    longint lim;
    lim = (longint'(1) << srm_pkg::FRAC_BITS) - 1;
    if (v > lim) begin
      return srm_pkg::value_t'(lim);
    end else if (v < -lim) begin
      return srm_pkg::value_t'(-lim);
    end
    return srm_pkg::value_t'(v);
  endfunction

  // Round half up from Q2.30 to the output format.
  function automatic srm_pkg::value_t q30_to_value(input longint v);
    return clamp_unit((v + (longint'(1) << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT);
  endfunction

  // Product of two rounded values, rounded half up back to the output format.
  function automatic srm_pkg::value_t scaled_product(input srm_pkg::value_t a,
                                                     input srm_pkg::value_t b);
    longint p;
    p = longint'(a) * longint'(b);
    return clamp_unit((p + (longint'(1) << (srm_pkg::FRAC_BITS - 1)))
                      >>> srm_pkg::FRAC_BITS);
  endfunction

  // Cosine and sine of one binary angle: fold to the first quadrant, run the
  // rotation-mode CORDIC on the residual, then unfold.
  function automatic void angle_cos_sin(input logic [srm_pkg::ANGLE_BITS-1:0] angle,
                                        output srm_pkg::value_t c,
                                        output srm_pkg::value_t s);
    longint         turn, z, x, y, dx, dy, rc, rs;
    srm_pkg::quad_t quad;
    turn = (longint'(angle) << (srm_pkg::TURN_BITS - srm_pkg::ANGLE_BITS))
           & 64'hFFFF_FFFF;
    quad = srm_pkg::quad_t'(turn[31:30]);
    z    = turn & 64'h3FFF_FFFF;
    x    = 64'h26DD_3B6A;
    y    = 0;
    for (int i = 0; i < srm_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - arctan_step[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + arctan_step[i];
      end
    end
    case (quad)
      srm_pkg::QUAD_FIRST:  begin rc = x;  rs = y;  end
      srm_pkg::QUAD_SECOND: begin rc = -y; rs = x;  end
      srm_pkg::QUAD_THIRD:  begin rc = -x; rs = -y; end
      default:              begin rc = y;  rs = -x; end
    endcase
    c = q30_to_value(rc);
    s = q30_to_value(rs);
  endfunction

  function automatic srm_pkg::result_t rotation_terms(input angle_pair_t p);
    srm_pkg::result_t r;
    srm_pkg::value_t  cb, sb, cl, sl;
    angle_cos_sin(p.beta, cb, sb);
    angle_cos_sin(p.lambda, cl, sl);
    r.cos_beta    = cb;
    r.sin_beta    = sb;
    r.cos_lambda  = cl;
    r.sin_lambda  = sl;
    r.cb_times_cl = scaled_product(cb, cl);
    r.cb_times_sl = scaled_product(cb, sl);
    r.sb_times_cl = scaled_product(sb, cl);
    r.sb_times_sl = scaled_product(sb, sl);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // One angle: mostly uniform over the turn; a quarter of the time close to a
  // quadrant edge, where the fold and the full-scale clamp matter most.
  function automatic logic [srm_pkg::ANGLE_BITS-1:0] random_angle();
    logic [srm_pkg::ANGLE_BITS-1:0] base;
    if ($urandom_range(3) == 0) begin
      base = srm_pkg::ANGLE_BITS'($urandom_range(3)) << (srm_pkg::ANGLE_BITS - 2);
      return base + srm_pkg::ANGLE_BITS'($urandom_range(16)) - srm_pkg::ANGLE_BITS'(8);
    end
    return srm_pkg::ANGLE_BITS'($urandom);
  endfunction

  task automatic queue_pair(input logic [srm_pkg::ANGLE_BITS-1:0] beta,
                            input logic [srm_pkg::ANGLE_BITS-1:0] lambda);
    angle_pair_t p;
    p.beta   = beta;
    p.lambda = lambda;
    pending_angles.push_back(p);
  endtask

  task automatic check_field(input string name, input srm_pkg::value_t want,
                             input srm_pkg::value_t got);
    if (got !== want) begin
      fail_count++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      #HALF_PERIOD clk = ~clk;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // Driver: offer the next pending request, or idle at random. Predict the
  // result on the edge where a request is accepted. A request that is
  // replaced by the next one in the same edge keeps in_valid high with a
  // single assignment.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_requests
    angle_pair_t next_pair;
    angle_pair_t taken;
    if (!rst_n) begin
      in_valid        <= 1'b0;
      in_beta_angle   <= '0;
      in_lambda_angle <= '0;
    end else begin
      if (in_valid && in_ready) begin
        taken.beta   = in_beta_angle;
        taken.lambda = in_lambda_angle;
        expected_terms.push_back(rotation_terms(taken));
      end
      // Hold the payload while a request waits; otherwise advance or idle.
      if (!in_valid || in_ready) begin
        if (pending_angles.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_pair       = pending_angles.pop_front();
          in_valid        <= 1'b1;
          in_beta_angle   <= next_pair.beta;
          in_lambda_angle <= next_pair.lambda;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each accepted result with the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    srm_pkg::result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_terms.size() == 0) begin
        fail_count++;
        $error("result with no request outstanding");
      end else begin
        want = expected_terms.pop_front();
        check_field("cos_beta",    want.cos_beta,    out_cos_beta);
        check_field("sin_beta",    want.sin_beta,    out_sin_beta);
        check_field("cos_lambda",  want.cos_lambda,  out_cos_lambda);
        check_field("sin_lambda",  want.sin_lambda,  out_sin_lambda);
        check_field("cb_times_cl", want.cb_times_cl, out_cb_times_cl);
        check_field("cb_times_sl", want.cb_times_sl, out_cb_times_sl);
        check_field("sb_times_cl", want.sb_times_cl, out_sb_times_cl);
        check_field("sb_times_sl", want.sb_times_sl, out_sb_times_sl);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: one directed set, then random requests in four idling phases:
  // none, sender mostly idle, receiver mostly stalled, both lightly.
  // --------------------------------------------------------------------------
  initial begin : run_phases
    int idle_by_phase  [NUM_PHASES];
    int stall_by_phase [NUM_PHASES];
    idle_by_phase  = '{0, 82, 0, 12};
    stall_by_phase = '{0, 0, 82, 12};
    @(posedge clk);
    while (!rst_n) @(posedge clk);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      send_idle_pct  = idle_by_phase[ph];
      recv_stall_pct = stall_by_phase[ph];
      if (ph == 0) begin
        // Quadrant edges: exact cos/sin of +/-1 exercise the full-scale clamp.
        queue_pair(16'h0000, 16'h0000);
        queue_pair(16'h4000, 16'h8000);
        queue_pair(16'hC000, 16'h0000);
        queue_pair(16'h8000, 16'hC000);
        // Just either side of each edge, and the all-ones angle.
        queue_pair(16'h0001, 16'hFFFF);
        queue_pair(16'h3FFF, 16'h4001);
        queue_pair(16'h7FFF, 16'h8001);
        queue_pair(16'hBFFF, 16'hC001);
        queue_pair(16'hFFFF, 16'hFFFF);
        // Octant midpoints: equal magnitudes, every sign combination.
        queue_pair(16'h2000, 16'h6000);
        queue_pair(16'hA000, 16'hE000);
        queue_pair(16'h6000, 16'h2000);
        queue_pair(16'hE000, 16'hA000);
        // Alternating bit patterns.
        queue_pair(16'h5555, 16'hAAAA);
        queue_pair(16'hAAAA, 16'h5555);
        queue_pair(16'h00FF, 16'hFF00);
      end
      repeat (PHASE_ITEMS) queue_pair(random_angle(), random_angle());
      // Drain before the idling pattern changes.
      while (pending_angles.size() != 0 || in_valid || expected_terms.size() != 0) begin
        @(posedge clk);
      end
    end

    // Let the pipeline run empty; anything that leaves now is unexpected.
    repeat (srm_pkg::PIPE_DEPTH + 8) @(posedge clk);
    if (expected_terms.size() != 0) begin
      fail_count++;
      $error("%0d predicted results never arrived", expected_terms.size());
    end
    if (fail_count == 0) begin
      $display("spherical_rotation_matrix regression: pass");
    end else begin
      $display("spherical_rotation_matrix regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of about 2000 requests.
  initial begin
    #(64'd200_000 * 2 * HALF_PERIOD);
    $display("spherical_rotation_matrix regression: fail");
    $finish;
  end

endmodule
